FILE: rtl/core/segment_to_quad_extruder_core_defines.svh
// assertion macros for the segment to quad extruder core
// used by the modules that carry concurrent checks
`ifndef SEGMENT_TO_QUAD_EXTRUDER_CORE_DEFINES_SVH
`define SEGMENT_TO_QUAD_EXTRUDER_CORE_DEFINES_SVH

// same-cycle implication
`define SQE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sqe check failed");

// next-cycle implication
`define SQE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sqe check failed");

`endif

FILE: rtl/core/sqe_pkg.sv
// shared types, widths, register indexes and reset values of the extruder
// no dependencies
`timescale 1ns / 1ps

package sqe_pkg;

   localparam int COORD_W     = 32;
   localparam int DIFF_W      = 33;
   localparam int VEC_W       = 34;
   localparam int NORM_W      = 16;
   localparam int OFF_W       = 24;
   localparam int WIDTH_W     = 23;
   localparam int MINLEN_W    = 17;
   localparam int VCOS_W      = 15;
   localparam int VIDX_W      = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = 2;
   localparam int REQ_TDATA_W = 6 * COORD_W;
   localparam int RSP_TDATA_W = 3 * COORD_W + 3 * NORM_W + VIDX_W;
   localparam int RSP_TUSER_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_RAPID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUT_WIDTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LENGTH   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTICAL_COS = 2'd3;

   localparam logic [WIDTH_W-1:0]  RAPID_WIDTH_RST  = 23'd13107;
   localparam logic [WIDTH_W-1:0]  CUT_WIDTH_RST    = 23'd32768;
   localparam logic [MINLEN_W-1:0] MIN_LENGTH_RST   = 17'd7;
   localparam logic [VCOS_W-1:0]   VERTICAL_COS_RST = 15'd16368;

   localparam logic [NORM_W-1:0] Q14_ONE = 16'd16384;

   typedef struct packed {
      logic [WIDTH_W-1:0]  rapid_width;
      logic [WIDTH_W-1:0]  cut_width;
      logic [MINLEN_W-1:0] min_length;
      logic [VCOS_W-1:0]   vertical_cos;
   } cfg_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] start_pt;
      logic [2:0][COORD_W-1:0] end_pt;
      logic [2:0][DIFF_W-1:0]  diff;
      logic                    rapid;
      logic                    short_seg;
   } seg_type;

   typedef struct packed {
      logic                   done;
      logic                   zero;
      logic [2:0][NORM_W-1:0] q;
   } norm_rsp_type;

   function automatic logic [DIFF_W-1:0] mag33(input logic [DIFF_W-1:0] x);
      mag33 = x[DIFF_W-1] ? (~x + 33'd1) : x;
   endfunction

endpackage

FILE: rtl/core/sqe_front.sv
// front end: takes segment items, forms the direction and sorts them
// uses sqe_pkg; feeds the queue in front of sqe_back
`timescale 1ns / 1ps

module sqe_front (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sqe_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   input  logic                             fifo_full,
   output logic                             push,
   output sqe_pkg::seg_type                 seg
);

   logic [sqe_pkg::COORD_W-1:0] s_pt, e_pt;
   logic [sqe_pkg::DIFF_W-1:0]  d, dm;
   logic                        nonzero, short_seg;

   always_comb begin
      nonzero   = 1'b0;
      short_seg = 1'b1;
      seg       = '0;
      for (int i = 0; i < 3; i++) begin
         s_pt = req_tdata[i*sqe_pkg::COORD_W +: sqe_pkg::COORD_W];
         e_pt = req_tdata[(i+3)*sqe_pkg::COORD_W +: sqe_pkg::COORD_W];
         d    = {e_pt[sqe_pkg::COORD_W-1], e_pt} - {s_pt[sqe_pkg::COORD_W-1], s_pt};
         dm   = sqe_pkg::mag33(d);
         if (d != '0) begin
            nonzero = 1'b1;
         end
         if (dm[sqe_pkg::DIFF_W-1:17] != '0) begin
            short_seg = 1'b0;
         end
         seg.start_pt[i] = s_pt;
         seg.end_pt[i]   = e_pt;
         seg.diff[i]     = d;
      end
      seg.rapid     = req_tuser;
      seg.short_seg = short_seg;
      req_tready    = !fifo_full;
      // zero-length items are dropped here
      push          = req_tvalid && req_tready && nonzero;
   end

endmodule

FILE: rtl/core/sqe_fifo.sv
// short item queue between the front end and the back end
// uses sqe_pkg for the item type
`timescale 1ns / 1ps

module sqe_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  sqe_pkg::seg_type wr_data,
   output logic             full,
   input  logic             rd_en,
   output sqe_pkg::seg_type rd_data,
   output logic             empty
);

   sqe_pkg::seg_type             mem_ff [sqe_pkg::FIFO_DEPTH];
   logic [sqe_pkg::FIFO_AW:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;

   always_comb begin
      empty     = (wr_ptr_ff == rd_ptr_ff);
      full      = (wr_ptr_ff[sqe_pkg::FIFO_AW] != rd_ptr_ff[sqe_pkg::FIFO_AW]) &&
                  (wr_ptr_ff[sqe_pkg::FIFO_AW-1:0] == rd_ptr_ff[sqe_pkg::FIFO_AW-1:0]);
      wr_ptr_in = wr_ptr_ff + ((wr_en && !full) ? 1'b1 : 1'b0);
      rd_ptr_in = rd_ptr_ff + ((rd_en && !empty) ? 1'b1 : 1'b0);
      rd_data   = mem_ff[rd_ptr_ff[sqe_pkg::FIFO_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && !full) begin
         mem_ff[wr_ptr_ff[sqe_pkg::FIFO_AW-1:0]] <= wr_data;
      end
   end

endmodule

FILE: rtl/core/sqe_norm.sv
// shared vector normalising unit: shift, sum of squares, bit-serial
// square root and restoring division to q2.14; uses sqe_pkg
`timescale 1ns / 1ps

module sqe_norm (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [2:0][sqe_pkg::VEC_W-1:0]      vec,
   output sqe_pkg::norm_rsp_type               rsp
);

   localparam logic [2:0] N_IDLE  = 3'd0;
   localparam logic [2:0] N_SHIFT = 3'd1;
   localparam logic [2:0] N_SQ    = 3'd2;
   localparam logic [2:0] N_SQRT  = 3'd3;
   localparam logic [2:0] N_DLOAD = 3'd4;
   localparam logic [2:0] N_DIV   = 3'd5;

   localparam int VW    = sqe_pkg::VEC_W;
   localparam int NUM_W = 46;

   logic [2:0]                 state_ff, state_in;
   logic                       done_ff, done_in;
   logic                       zero_ff, zero_in;
   logic [2:0][VW-1:0]         mag_ff, mag_in;
   logic [2:0]                 neg_ff, neg_in;
   logic [VW-1:0]              mx_ff, mx_in, mx;
   logic [1:0]                 cnt_ff, cnt_in;
   logic [61:0]                prod_ff, prod_in;
   logic [63:0]                sum_ff, sum_in, sum_add;
   logic [63:0]                rem_ff, rem_in;
   logic [63:0]                res_ff, res_in;
   logic [63:0]                bit_ff, bit_in, trial;
   logic [NUM_W-1:0]           num_ff, num_in, dtrial;
   logic [3:0]                 bidx_ff, bidx_in;
   logic [14:0]                quo_ff, quo_in;
   logic [2:0][sqe_pkg::NORM_W-1:0] q_ff, q_in;
   logic [VW-1:0]              m;

   function automatic logic [VW-1:0] mag34(input logic [VW-1:0] x);
      mag34 = x[VW-1] ? (~x + 34'd1) : x;
   endfunction

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      zero_in  = zero_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      mx_in    = mx_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      sum_in   = sum_ff;
      rem_in   = rem_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      num_in   = num_ff;
      bidx_in  = bidx_ff;
      quo_in   = quo_ff;
      q_in     = q_ff;
      mx       = '0;
      m        = '0;
      sum_add  = sum_ff + {2'b00, prod_ff};
      trial    = res_ff + bit_ff;
      dtrial   = {14'd0, res_ff[31:0]} << bidx_ff;
      case (state_ff)
         N_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag34(vec[i]);
                  neg_in[i] = vec[i][VW-1];
                  if (mag_in[i] > mx) begin
                     mx = mag_in[i];
                  end
               end
               mx_in = mx;
               if (mx == '0) begin
                  zero_in = 1'b1;
                  q_in    = '0;
                  done_in = 1'b1;
               end else begin
                  zero_in  = 1'b0;
                  state_in = N_SHIFT;
               end
            end
         end
         N_SHIFT: begin
            if (mx_ff[VW-1:31] != '0) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] >> 1;
               end
               mx_in = mx_ff >> 1;
            end else if (!mx_ff[30]) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] << 1;
               end
               mx_in = mx_ff << 1;
            end else begin
               cnt_in   = 2'd0;
               sum_in   = '0;
               state_in = N_SQ;
            end
         end
         N_SQ: begin
            if (cnt_ff != 2'd3) begin
               m       = mag_ff[cnt_ff];
               prod_in = {31'd0, m[30:0]} * {31'd0, m[30:0]};
            end
            if (cnt_ff != 2'd0) begin
               sum_in = sum_add;
            end
            if (cnt_ff == 2'd3) begin
               rem_in   = sum_add;
               res_in   = '0;
               bit_in   = 64'h4000_0000_0000_0000;
               state_in = N_SQRT;
            end else begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         N_SQRT: begin
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               cnt_in   = 2'd0;
               state_in = N_DLOAD;
            end
         end
         N_DLOAD: begin
            m        = mag_ff[cnt_ff];
            num_in   = {1'b0, m[30:0], 14'd0} + {15'd0, res_ff[31:1]};
            bidx_in  = 4'd14;
            quo_in   = '0;
            state_in = N_DIV;
         end
         N_DIV: begin
            if (num_ff >= dtrial) begin
               num_in          = num_ff - dtrial;
               quo_in[bidx_ff] = 1'b1;
            end
            if (bidx_ff == 4'd0) begin
               q_in[cnt_ff] = neg_ff[cnt_ff] ? (~{1'b0, quo_in} + 16'd1) : {1'b0, quo_in};
               if (cnt_ff == 2'd2) begin
                  done_in  = 1'b1;
                  state_in = N_IDLE;
               end else begin
                  cnt_in   = cnt_ff + 2'd1;
                  state_in = N_DLOAD;
               end
            end else begin
               bidx_in = bidx_ff - 4'd1;
            end
         end
         default: begin
            state_in = N_IDLE;
         end
      endcase
      rsp.done = done_ff;
      rsp.zero = zero_ff;
      rsp.q    = q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= zero_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      mx_ff   <= mx_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      num_ff  <= num_in;
      bidx_ff <= bidx_in;
      quo_ff  <= quo_in;
      q_ff    <= q_in;
   end

endmodule

FILE: rtl/core/sqe_back.sv
// back end sequencer: length check, offsets, cross product, corner output
// uses sqe_pkg, drives sqe_norm and the defines header for checks
`timescale 1ns / 1ps
`include "segment_to_quad_extruder_core_defines.svh"

module sqe_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sqe_pkg::cfg_type                     cfg,
   input  sqe_pkg::seg_type                     seg,
   input  logic                                 fifo_empty,
   output logic                                 fifo_pop,
   output logic                                 norm_start,
   output logic [2:0][sqe_pkg::VEC_W-1:0]       norm_vec,
   input  sqe_pkg::norm_rsp_type                norm_rsp,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sqe_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [sqe_pkg::RSP_TUSER_W-1:0]      rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam logic [3:0] B_IDLE  = 4'd0;
   localparam logic [3:0] B_SHORT = 4'd1;
   localparam logic [3:0] B_DIR   = 4'd2;
   localparam logic [3:0] B_DIRW  = 4'd3;
   localparam logic [3:0] B_SIDE  = 4'd4;
   localparam logic [3:0] B_SIDEW = 4'd5;
   localparam logic [3:0] B_OFFS  = 4'd6;
   localparam logic [3:0] B_CROSS = 4'd7;
   localparam logic [3:0] B_NORM  = 4'd8;
   localparam logic [3:0] B_NORMW = 4'd9;
   localparam logic [3:0] B_EMIT  = 4'd10;

   localparam int CW = sqe_pkg::COORD_W;
   localparam int NW = sqe_pkg::NORM_W;
   localparam int VW = sqe_pkg::VEC_W;
   localparam int OW = sqe_pkg::OFF_W;

   logic [3:0]               state_ff, state_in;
   logic [2:0]               cnt_ff, cnt_in;
   sqe_pkg::seg_type         seg_ff, seg_in;
   logic [2:0][NW-1:0]       u_ff, u_in, p_ff, p_in, n_ff, n_in;
   logic [2:0][OW-1:0]       off_ff, off_in;
   logic [2:0][VW-1:0]       nv_ff, nv_in;
   logic [35:0]              sq_ff, sq_in;
   logic [63:0]              prod_ff, prod_in, rnd_sum;
   logic                     psign_ff, psign_in;
   logic [sqe_pkg::VIDX_W-1:0] vcount_ff, vcount_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [2:0][CW-1:0]       pos_ff, pos_in;
   logic [2:0][NW-1:0]       nrm_ff, nrm_in;
   logic                     rapid_ff, rapid_in, at_end_ff, at_end_in, last_ff, last_in;
   logic [sqe_pkg::VIDX_W-1:0] vidx_ff, vidx_in;

   logic [31:0]              opa, opb;
   logic [32:0]              dmag;
   logic [OW-1:0]            rnd;
   logic [NW-1:0]            pa, pb;
   logic                     sub;
   logic [1:0]               idx;
   logic [2:0]               cm1;
   logic [sqe_pkg::WIDTH_W-1:0] wsel;
   logic [CW-1:0]            base;
   logic [VW-1:0]            bsum;
   logic                     plus, out_free, emit_load;

   function automatic logic [NW-1:0] abs16(input logic [NW-1:0] x);
      abs16 = x[NW-1] ? (~x + 16'd1) : x;
   endfunction

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      seg_in       = seg_ff;
      u_in         = u_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      off_in       = off_ff;
      nv_in        = nv_ff;
      sq_in        = sq_ff;
      psign_in     = psign_ff;
      vcount_in    = vcount_ff;
      rsp_valid_in = rsp_valid_ff;
      pos_in       = pos_ff;
      nrm_in       = nrm_ff;
      rapid_in     = rapid_ff;
      at_end_in    = at_end_ff;
      last_in      = last_ff;
      vidx_in      = vidx_ff;
      fifo_pop     = 1'b0;
      norm_start   = 1'b0;
      norm_vec     = '0;
      opa          = '0;
      opb          = '0;
      dmag         = '0;
      pa           = '0;
      pb           = '0;
      sub          = 1'b0;
      base         = '0;
      bsum         = '0;
      plus         = 1'b0;
      emit_load    = 1'b0;
      cm1          = cnt_ff - 3'd1;
      idx          = cm1[2:1];
      rnd_sum      = prod_ff + 64'd16384;
      rnd          = rnd_sum[38:15];
      wsel         = seg_ff.rapid ? cfg.rapid_width : cfg.cut_width;
      out_free     = !rsp_valid_ff || rsp_tready;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         B_IDLE: begin
            if (!fifo_empty) begin
               fifo_pop = 1'b1;
               seg_in   = seg;
               cnt_in   = '0;
               sq_in    = '0;
               nv_in    = '0;
               state_in = seg.short_seg ? B_SHORT : B_DIR;
            end
         end
         B_SHORT: begin
            if (cnt_ff < 3'd3) begin
               dmag = sqe_pkg::mag33(seg_ff.diff[cnt_ff[1:0]]);
               opa  = dmag[31:0];
               opb  = dmag[31:0];
            end else if (cnt_ff == 3'd3) begin
               opa = {15'd0, cfg.min_length};
               opb = {15'd0, cfg.min_length};
            end
            if (cnt_ff != 3'd0 && cnt_ff != 3'd4) begin
               sq_in = sq_ff + prod_ff[35:0];
            end
            if (cnt_ff == 3'd4) begin
               state_in = (sq_ff < prod_ff[35:0]) ? B_IDLE : B_DIR;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         B_DIR: begin
            norm_start = 1'b1;
            for (int i = 0; i < 3; i++) begin
               norm_vec[i] = {seg_ff.diff[i][32], seg_ff.diff[i]};
            end
            state_in = B_DIRW;
         end
         B_DIRW: begin
            if (norm_rsp.done) begin
               u_in     = norm_rsp.q;
               state_in = B_SIDE;
            end
         end
         B_SIDE: begin
            cnt_in = '0;
            if (abs16(u_ff[2]) > {1'b0, cfg.vertical_cos}) begin
               p_in     = {16'd0, 16'd0, sqe_pkg::Q14_ONE};
               state_in = B_OFFS;
            end else begin
               norm_start  = 1'b1;
               norm_vec[0] = {seg_ff.diff[1][32], seg_ff.diff[1]};
               norm_vec[1] = '0 - {seg_ff.diff[0][32], seg_ff.diff[0]};
               norm_vec[2] = '0;
               state_in    = B_SIDEW;
            end
         end
         B_SIDEW: begin
            if (norm_rsp.done) begin
               p_in     = norm_rsp.zero ? {16'd0, 16'd0, sqe_pkg::Q14_ONE} : norm_rsp.q;
               state_in = B_OFFS;
            end
         end
         B_OFFS: begin
            if (cnt_ff < 3'd3) begin
               opa      = {16'd0, abs16(p_ff[cnt_ff[1:0]])};
               opb      = {9'd0, wsel};
               psign_in = p_ff[cnt_ff[1:0]][NW-1];
            end
            if (cnt_ff != 3'd0) begin
               off_in[cm1[1:0]] = psign_ff ? (~rnd + 24'd1) : rnd;
            end
            if (cnt_ff == 3'd3) begin
               cnt_in   = '0;
               state_in = B_CROSS;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         B_CROSS: begin
            // terms of cross(p, u), two per component
            case (cnt_ff)
               3'd0: begin pa = p_ff[1]; pb = u_ff[2]; sub = 1'b0; end
               3'd1: begin pa = p_ff[2]; pb = u_ff[1]; sub = 1'b1; end
               3'd2: begin pa = p_ff[2]; pb = u_ff[0]; sub = 1'b0; end
               3'd3: begin pa = p_ff[0]; pb = u_ff[2]; sub = 1'b1; end
               3'd4: begin pa = p_ff[0]; pb = u_ff[1]; sub = 1'b0; end
               3'd5: begin pa = p_ff[1]; pb = u_ff[0]; sub = 1'b1; end
               default: begin pa = '0; pb = '0; sub = 1'b0; end
            endcase
            if (cnt_ff < 3'd6) begin
               opa      = {16'd0, abs16(pa)};
               opb      = {16'd0, abs16(pb)};
               psign_in = pa[NW-1] ^ pb[NW-1] ^ sub;
            end
            if (cnt_ff != 3'd0) begin
               nv_in[idx] = psign_ff ? (nv_ff[idx] - prod_ff[VW-1:0])
                                     : (nv_ff[idx] + prod_ff[VW-1:0]);
            end
            if (cnt_ff == 3'd6) begin
               state_in = B_NORM;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         B_NORM: begin
            norm_start = 1'b1;
            norm_vec   = nv_ff;
            state_in   = B_NORMW;
         end
         B_NORMW: begin
            if (norm_rsp.done) begin
               n_in     = norm_rsp.q;
               cnt_in   = '0;
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (out_free) begin
               emit_load = 1'b1;
               plus      = (cnt_ff[1:0] == 2'd1) || (cnt_ff[1:0] == 2'd2);
               for (int i = 0; i < 3; i++) begin
                  base = cnt_ff[1] ? seg_ff.end_pt[i] : seg_ff.start_pt[i];
                  bsum = plus ? ({{2{base[CW-1]}}, base} + {{10{off_ff[i][OW-1]}}, off_ff[i]})
                              : ({{2{base[CW-1]}}, base} - {{10{off_ff[i][OW-1]}}, off_ff[i]});
                  if (bsum[VW-1:CW-1] == 3'b000 || bsum[VW-1:CW-1] == 3'b111) begin
                     pos_in[i] = bsum[CW-1:0];
                  end else begin
                     pos_in[i] = bsum[VW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
                  end
               end
               nrm_in       = n_ff;
               rapid_in     = seg_ff.rapid;
               at_end_in    = cnt_ff[1];
               last_in      = (cnt_ff[1:0] == 2'd3);
               vidx_in      = vcount_ff;
               vcount_in    = vcount_ff + 32'd1;
               rsp_valid_in = 1'b1;
               if (cnt_ff[1:0] == 2'd3) begin
                  state_in = B_IDLE;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      prod_in = {32'd0, opa} * {32'd0, opb};
   end

   assign rsp_tvalid = rsp_valid_ff;
   // tdata: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, vertex_index
   assign rsp_tdata  = {vidx_ff, nrm_ff[2], nrm_ff[1], nrm_ff[0], pos_ff[2], pos_ff[1], pos_ff[0]};
   // tuser: rapid_flag, at_end
   assign rsp_tuser  = {at_end_ff, rapid_ff};
   assign rsp_tlast  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         vcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      seg_ff    <= seg_in;
      u_ff      <= u_in;
      p_ff      <= p_in;
      n_ff      <= n_in;
      off_ff    <= off_in;
      nv_ff     <= nv_in;
      sq_ff     <= sq_in;
      prod_ff   <= prod_in;
      psign_ff  <= psign_in;
      pos_ff    <= pos_in;
      nrm_ff    <= nrm_in;
      rapid_ff  <= rapid_in;
      at_end_ff <= at_end_in;
      last_ff   <= last_in;
      vidx_ff   <= vidx_in;
   end

   `SQE_ASSERT_IMP(a_done_in_wait, clock, reset, norm_rsp.done, state_ff == B_DIRW || state_ff == B_SIDEW || state_ff == B_NORMW)
   `SQE_ASSERT_NXT(a_vcount_step, clock, reset, emit_load, vcount_ff == $past(vcount_ff) + 32'd1)
   `SQE_ASSERT_IMP(a_last_index, clock, reset, rsp_valid_ff && last_ff, vidx_ff[1:0] == 2'd3 && at_end_ff)

endmodule

FILE: rtl/core/segment_to_quad_extruder_core.sv
// segment to quad extruder top level: config registers, front end, queue,
// back end sequencer and the shared normalising unit; uses sqe_pkg
// a kept segment runs the shared normaliser (one shift a cycle, 32-step root, then a
// divide per component) two or three times, then emits four corner items; short items
// first get a length check against min_length, zero-length ones are dropped at once
// reset is synchronous: registers to defaults, vertex index to zero, queue empty
`timescale 1ns / 1ps

module segment_to_quad_extruder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: start_x, start_y, start_z, end_x, end_y, end_z
   input  logic [sqe_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // tuser: is_rapid
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, vertex_index
   output logic [sqe_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // tuser: rapid_flag, at_end
   output logic [sqe_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [sqe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sqe_pkg::WIDTH_W-1:0]         csr_wdata
);

   sqe_pkg::cfg_type             cfg_ff, cfg_in;
   sqe_pkg::seg_type             front_seg, fifo_seg;
   sqe_pkg::norm_rsp_type        norm_rsp;
   logic                         push, fifo_full, fifo_empty, fifo_pop, norm_start;
   logic [2:0][sqe_pkg::VEC_W-1:0] norm_vec;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            sqe_pkg::CSR_RAPID_WIDTH:  cfg_in.rapid_width  = csr_wdata;
            sqe_pkg::CSR_CUT_WIDTH:    cfg_in.cut_width    = csr_wdata;
            sqe_pkg::CSR_MIN_LENGTH:   cfg_in.min_length   = csr_wdata[sqe_pkg::MINLEN_W-1:0];
            sqe_pkg::CSR_VERTICAL_COS: cfg_in.vertical_cos = csr_wdata[sqe_pkg::VCOS_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rapid_width  <= sqe_pkg::RAPID_WIDTH_RST;
         cfg_ff.cut_width    <= sqe_pkg::CUT_WIDTH_RST;
         cfg_ff.min_length   <= sqe_pkg::MIN_LENGTH_RST;
         cfg_ff.vertical_cos <= sqe_pkg::VERTICAL_COS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sqe_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .fifo_full  (fifo_full),
      .push       (push),
      .seg        (front_seg)
   );

   sqe_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (front_seg),
      .full    (fifo_full),
      .rd_en   (fifo_pop),
      .rd_data (fifo_seg),
      .empty   (fifo_empty)
   );

   sqe_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .vec   (norm_vec),
      .rsp   (norm_rsp)
   );

   sqe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .seg        (fifo_seg),
      .fifo_empty (fifo_empty),
      .fifo_pop   (fifo_pop),
      .norm_start (norm_start),
      .norm_vec   (norm_vec),
      .norm_rsp   (norm_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
